@@ rtl/wgm_pkg.sv @@
`default_nettype none

package wgm_pkg;

    // Request kinds carried in req_type
    typedef enum logic [1:0] {
        REQ_PATTERN = 2'd0,
        REQ_TEXT    = 2'd1,
        REQ_END     = 2'd2
    } t_req_type;

    // Pattern bytes with a special meaning
    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic       pat_we;     // store ch at the write index
        logic       restart;    // drop the reachable set back to position zero
        logic       text_step;  // advance the reachable set by one text byte
        logic [7:0] ch;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ rtl/wgm_req_if.sv @@
`default_nettype none

interface wgm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] ch;
    logic       first;

    modport source (output valid, output req_type, output ch, output first, input ready);
    modport sink   (input valid, input req_type, input ch, input first, output ready);
endinterface

`default_nettype wire

@@ rtl/wgm_res_if.sv @@
`default_nettype none

interface wgm_res_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/wgm_cell.sv @@
`default_nettype none

module wgm_cell #(
    parameter int INDEX = 0,
    parameter int LW    = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wgm_pkg::t_cell_ctl  i_ctl,
    input  logic [LW-1:0]       i_wr_idx,
    input  logic [LW-1:0]       i_len,
    input  logic                i_closed,
    input  logic                i_fwd,
    output logic                o_fwd,
    output logic                o_raw,
    output logic                o_prop
);
    import wgm_pkg::*;

    logic [7:0] r_pat;
    logic       r_reach;
    logic       n_reach;
    logic       w_active;
    logic       w_star;
    logic       w_hit;
    logic       w_keep;

    // Decode the stored pattern byte against the current text byte
    assign w_active = LW'(INDEX) < i_len;
    assign w_star   = (r_pat == STAR_BYTE);
    assign w_hit    = (r_pat == ANY_BYTE) || (r_pat == i_ctl.ch);

    // A star lets reach flow on without consuming text
    assign o_prop = w_active & w_star;
    // A literal or any-byte hit hands reach to the next cell
    assign o_fwd  = i_closed & w_active & ~w_star & w_hit;
    // A reached star stays reached across the byte
    assign w_keep = i_closed & o_prop;
    assign o_raw  = r_reach;

    always_comb begin
        n_reach = r_reach;
        if (i_ctl.restart) begin
            n_reach = (INDEX == 0);
        end else if (i_ctl.text_step) begin
            n_reach = w_keep | i_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reach <= (INDEX == 0);
        end else begin
            r_reach <= n_reach;
        end
    end

    // Capture the pattern byte when this cell is the write target
    always_ff @(posedge i_clk) begin
        if (i_ctl.pat_we && (i_wr_idx == LW'(INDEX))) begin
            r_pat <= i_ctl.ch;
        end
    end

endmodule

`default_nettype wire

@@ rtl/wgm_closure.sv @@
`default_nettype none

module wgm_closure #(
    parameter int WIDTH = 33
) (
    input  logic [WIDTH-1:0] i_raw,
    input  logic [WIDTH-1:1] i_prop,
    output logic [WIDTH-1:0] o_closed
);
    localparam int LV = $clog2(WIDTH);

    // Segmented prefix OR: reach at j spreads to j+1 while j is an active star
    logic [WIDTH-1:0] g [0:LV];
    logic [WIDTH-1:0] p [0:LV];

    assign g[0] = i_raw;
    assign p[0] = {i_prop, 1'b0};

    for (genvar k = 0; k < LV; k++) begin : g_level
        localparam int D = 1 << k;
        for (genvar j = 0; j < WIDTH; j++) begin : g_bit
            if (j >= D) begin : g_merge
                assign g[k+1][j] = g[k][j] | (p[k][j] & g[k][j-D]);
                assign p[k+1][j] = p[k][j] & p[k][j-D];
            end else begin : g_pass
                assign g[k+1][j] = g[k][j];
                assign p[k+1][j] = 1'b0;
            end
        end
    end

    assign o_closed = g[LV];

endmodule

`default_nettype wire

@@ rtl/wildcard_glob_matcher_top.sv @@
// Glob matcher with '*' (any run of bytes) and '?' (any single byte).
// Request channel i_req: one word per item. req_type selects a pattern
// byte (ch appended to the stored pattern; first empties the pattern and
// clears the overflow flag beforehand), a text byte, or end of text.
// Result channel o_res: one word per end item, giving matched and
// pattern_overflow, then the text restarts at pattern position zero.
// Pattern bytes past PATTERN_MAX are dropped and raise pattern_overflow.
// Throughput: one request word per cycle, any mix of kinds, unless held
// results are blocked. An accepted end item's result is valid next cycle.
// Each pattern position is a cell holding its byte and reach bit; a star
// closure network of clog2(PATTERN_MAX+1) levels sets the cycle path.
// Reset empties the pattern, clears the overflow flag and any pending
// result, and leaves only position zero reachable. While a result waits
// on o_res.ready the block takes no word of any kind; i_req stalls only
// when a result is held and the receiver is not ready.
`default_nettype none

module wildcard_glob_matcher_top #(
    parameter int PATTERN_MAX = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wgm_req_if.sink       i_req,
    wgm_res_if.source     o_res
);
    import wgm_pkg::*;

    localparam int LW = $clog2(PATTERN_MAX + 1);

    logic [LW-1:0]        r_len;
    logic [LW-1:0]        n_len;
    logic                 r_ovf;
    logic                 n_ovf;
    logic                 r_reach_end;
    logic                 n_reach_end;
    logic                 r_out_valid;
    logic                 r_matched;
    logic                 r_povf;

    t_req_type            w_kind;
    t_cell_ctl            w_ctl;
    logic                 w_accept;
    logic                 w_end;
    logic [LW-1:0]        w_wr_idx;
    logic                 w_room;
    logic [PATTERN_MAX:0] w_raw;
    logic [PATTERN_MAX:0] w_closed;
    logic [PATTERN_MAX:1] w_prop;
    logic [PATTERN_MAX:0] w_fwd;

    // Take a word unless a held result is still blocked
    assign i_req.ready = ~r_out_valid | o_res.ready;
    assign w_accept    = i_req.valid & i_req.ready;
    assign w_kind      = t_req_type'(i_req.req_type);

    // Write position and room for a pattern byte
    assign w_wr_idx = i_req.first ? '0 : r_len;
    assign w_room   = w_wr_idx < LW'(PATTERN_MAX);

    // Decode the word into cell commands and pattern bookkeeping
    always_comb begin
        w_ctl.pat_we    = 1'b0;
        w_ctl.restart   = 1'b0;
        w_ctl.text_step = 1'b0;
        w_ctl.ch        = i_req.ch;
        w_end           = 1'b0;
        n_len           = r_len;
        n_ovf           = r_ovf;
        if (w_accept) begin
            unique case (w_kind)
                REQ_PATTERN: begin
                    w_ctl.pat_we  = w_room;
                    w_ctl.restart = 1'b1;
                    n_len         = w_room ? w_wr_idx + LW'(1) : w_wr_idx;
                    n_ovf         = (r_ovf & ~i_req.first) | ~w_room;
                end
                REQ_TEXT: begin
                    w_ctl.text_step = 1'b1;
                end
                REQ_END: begin
                    w_ctl.restart = 1'b1;
                    w_end         = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Row of pattern cells, reach handed left to right
    assign w_fwd[0] = 1'b0;

    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        wgm_cell #(
            .INDEX (i),
            .LW    (LW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_wr_idx (w_wr_idx),
            .i_len    (r_len),
            .i_closed (w_closed[i]),
            .i_fwd    (w_fwd[i]),
            .o_fwd    (w_fwd[i+1]),
            .o_raw    (w_raw[i]),
            .o_prop   (w_prop[i+1])
        );
    end

    // Position past the last pattern byte has no cell of its own
    assign w_raw[PATTERN_MAX] = r_reach_end;

    always_comb begin
        n_reach_end = r_reach_end;
        if (w_ctl.restart) begin
            n_reach_end = 1'b0;
        end else if (w_ctl.text_step) begin
            n_reach_end = w_fwd[PATTERN_MAX];
        end
    end

    wgm_closure #(
        .WIDTH (PATTERN_MAX + 1)
    ) u_closure (
        .i_raw    (w_raw),
        .i_prop   (w_prop),
        .o_closed (w_closed)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_reach_end <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_reach_end <= n_reach_end;
            if (w_end) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (w_end) begin
            r_matched <= w_closed[r_len];
            r_povf    <= r_ovf;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.matched          = r_matched;
    assign o_res.pattern_overflow = r_povf;

endmodule

`default_nettype wire

@@ rtl/wgm_checker.sv @@
`default_nettype none

module wgm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic [1:0] i_req_type,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic       i_res_matched,
    input logic       i_res_povf
);
    import wgm_pkg::*;

    logic w_end_acc;

    assign w_end_acc = i_req_valid & i_req_ready & (i_req_type == REQ_END);

    // A stalled result word holds its value
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_res_matched) && $stable(i_res_povf)))
        else $error("result word changed while stalled");

    // Every accepted end item shows a result in the next cycle
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end_acc |=> i_res_valid)
        else $error("end item gave no result");

    // No result appears without an end item or a held word
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(w_end_acc))
        else $error("result word without end item");

    // A blocked result keeps the request side stalled
    a_backpress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |-> !i_req_ready)
        else $error("request taken while result blocked");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result pending after reset");

endmodule

bind wildcard_glob_matcher_top wgm_checker u_wgm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_req_type    (i_req.req_type),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_matched (o_res.matched),
    .i_res_povf    (o_res.pattern_overflow)
);

`default_nettype wire
